/* design/stable_priority_queue_assert.svh */
// Assertion macros for the stable priority queue.
// Included by the top level; depends on nothing else.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stable_priority_queue: same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stable_priority_queue: next-cycle check failed");

`endif

/* design/spq_pkg.sv */
// Shared types and constants for the stable priority queue.
// Used by spq_cell and stable_priority_queue; depends on nothing.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 16;
  localparam int OCC_W    = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } cell_cmd_t;

endpackage

/* design/spq_cell.sv */
// One slot of the sorted queue: holds a value and a priority and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell (
  input  logic                              clk_i,
  input  spq_pkg::cell_cmd_t                cmd_i,
  input  logic                              occ_i,
  input  logic                              left_gt_i,
  input  logic signed [spq_pkg::VALUE_W-1:0] left_value_i,
  input  logic signed [spq_pkg::PRIO_W-1:0]  left_prio_i,
  input  logic signed [spq_pkg::VALUE_W-1:0] right_value_i,
  input  logic signed [spq_pkg::PRIO_W-1:0]  right_prio_i,
  output logic                              gt_o,
  output logic signed [spq_pkg::VALUE_W-1:0] value_o,
  output logic signed [spq_pkg::PRIO_W-1:0]  prio_o
);

  logic signed [spq_pkg::VALUE_W-1:0] value_q, value_d;
  logic signed [spq_pkg::PRIO_W-1:0]  prio_q, prio_d;

  // A free slot or one with a strictly larger priority lies behind the new entry.
  assign gt_o = !occ_i || (prio_q > cmd_i.prio);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (cmd_i.ins && gt_o) begin
      if (left_gt_i) begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end else begin
        value_d = cmd_i.value;
        prio_d  = cmd_i.prio;
      end
    end else if (cmd_i.rem) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

/* design/stable_priority_queue.sv */
// Sorted priority queue built from a row of slot cells, with a registered result.
// Depends on spq_pkg, spq_cell and stable_priority_queue_assert.svh.
//
// The queue takes one request per clock cycle and delivers its result in the cycle after
// acceptance. Every slot compares its priority with the incoming one in parallel and the
// whole row shifts in the same cycle; a new request is taken whenever the result register
// is empty or being read. Equal priorities leave in arrival order. Slot contents are
// undefined after reset and only the entry count and the result valid flag are cleared,
// so the queue is usable as soon as reset is released.
`include "stable_priority_queue_assert.svh"

module stable_priority_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               command_i,
  input  logic signed [spq_pkg::VALUE_W-1:0] entry_value_i,
  input  logic signed [spq_pkg::PRIO_W-1:0]  entry_priority_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [spq_pkg::VALUE_W-1:0] removed_value_o,
  output logic [1:0]                         status_o,
  output logic [spq_pkg::OCC_W-1:0]          occupancy_o
);

  logic [spq_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      out_valid_q;
  logic signed [spq_pkg::VALUE_W-1:0] removed_value_q, removed_value_d;
  spq_pkg::status_e          status_q, status_d;
  logic [spq_pkg::OCC_W-1:0] occupancy_q;
  logic [spq_pkg::CNT_W+spq_pkg::OCC_W-1:0] cnt_ext;

  logic accept, is_remove, full, empty, ins_ok, rem_ok;
  spq_pkg::cell_cmd_t cmd;

  logic [spq_pkg::CAPACITY-1:0] occ;
  logic [spq_pkg::CAPACITY-1:0] gt;
  logic signed [spq_pkg::VALUE_W-1:0] cell_value [spq_pkg::CAPACITY];
  logic signed [spq_pkg::PRIO_W-1:0]  cell_prio  [spq_pkg::CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_remove  = (command_i == spq_pkg::CMD_REMOVE);
  assign full       = (cnt_q == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign empty      = (cnt_q == '0);
  assign ins_ok     = accept && !is_remove && !full;
  assign rem_ok     = accept && is_remove && !empty;

  assign cmd.ins   = ins_ok;
  assign cmd.rem   = rem_ok;
  assign cmd.value = entry_value_i;
  assign cmd.prio  = entry_priority_i;

  for (genvar g = 0; g < spq_pkg::CAPACITY; g++) begin : g_cell
    logic                               left_gt;
    logic signed [spq_pkg::VALUE_W-1:0] left_value, right_value;
    logic signed [spq_pkg::PRIO_W-1:0]  left_prio, right_prio;

    assign occ[g] = (cnt_q > spq_pkg::CNT_W'(g));

    if (g == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_value = entry_value_i;
      assign left_prio  = entry_priority_i;
    end else begin : g_mid
      assign left_gt    = gt[g-1];
      assign left_value = cell_value[g-1];
      assign left_prio  = cell_prio[g-1];
    end

    if (g == spq_pkg::CAPACITY - 1) begin : g_last
      assign right_value = cell_value[g];
      assign right_prio  = cell_prio[g];
    end else begin : g_inner
      assign right_value = cell_value[g+1];
      assign right_prio  = cell_prio[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ[g]),
      .left_gt_i    (left_gt),
      .left_value_i (left_value),
      .left_prio_i  (left_prio),
      .right_value_i(right_value),
      .right_prio_i (right_prio),
      .gt_o         (gt[g]),
      .value_o      (cell_value[g]),
      .prio_o       (cell_prio[g])
    );
  end

  always_comb begin
    cnt_d           = cnt_q;
    removed_value_d = '0;
    status_d        = spq_pkg::ST_DONE;
    if (is_remove) begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        removed_value_d = cell_value[0];
        cnt_d           = cnt_q - 1'b1;
      end
    end else begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  assign cnt_ext = {{spq_pkg::OCC_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_value_q <= removed_value_d;
      status_q        <= status_d;
      occupancy_q     <= cnt_ext[spq_pkg::OCC_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_value_q;
  assign status_o        = status_q;
  assign occupancy_o     = occupancy_q;

  `SPQ_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
  `SPQ_ASSERT_NOW(a_head_sorted, clk_i, rst_ni, occ[1], cell_prio[0] <= cell_prio[1])
  `SPQ_ASSERT_NEXT(a_remove_head, clk_i, rst_ni, rem_ok, removed_value_o == $past(cell_value[0]))
  `SPQ_ASSERT_NEXT(a_remove_count, clk_i, rst_ni, rem_ok, cnt_q == $past(cnt_q) - 1'b1)

endmodule

/* dv/stable_priority_queue_tb.sv */
// Self-checking testbench for stable_priority_queue: drives insert and remove requests with
// random gaps and result back-pressure, predicts each result with a sorted-array model and
// compares every field. Depends on spq_pkg and the stable_priority_queue RTL.
module stable_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  localparam int RX_FREE     = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_SLOW     = 2;
  localparam int RX_PERIODIC = 3;

  typedef struct packed {
    logic signed [spq_pkg::VALUE_W-1:0] value;
    spq_pkg::status_e                   status;
    logic [spq_pkg::OCC_W-1:0]          occ;
  } spq_result_t;

  logic                               clk_i;
  logic                               rst_ni           = 1'b0;
  logic                               in_valid_i       = 1'b0;
  logic                               in_ready_o;
  logic                               command_i        = 1'b0;
  logic signed [spq_pkg::VALUE_W-1:0] entry_value_i    = '0;
  logic signed [spq_pkg::PRIO_W-1:0]  entry_priority_i = '0;
  logic                               out_valid_o;
  logic                               out_ready_i      = 1'b0;
  logic signed [spq_pkg::VALUE_W-1:0] removed_value_o;
  logic [1:0]                         status_o;
  logic [spq_pkg::OCC_W-1:0]          occupancy_o;

  logic [spq_pkg::VALUE_W-1:0]       queue_value [spq_pkg::CAPACITY];
  logic signed [spq_pkg::PRIO_W-1:0] queue_prio  [spq_pkg::CAPACITY];
  int                                queue_count = 0;

  spq_result_t pending_results[$];

  int  cycle_count   = 0;
  int  error_count   = 0;
  int  checked_count = 0;
  int  insert_count  = 0;
  int  remove_count  = 0;
  int  full_count    = 0;
  int  empty_count   = 0;
  bit  gaps_on       = 1'b1;
  int  burst_left    = 0;
  bit  hold_req      = 1'b0;

  stable_priority_queue u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .entry_value_i    (entry_value_i),
    .entry_priority_i (entry_priority_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .removed_value_o  (removed_value_o),
    .status_o         (status_o),
    .occupancy_o      (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic spq_result_t predict_result(spq_pkg::command_e cmd,
                                                 logic [spq_pkg::VALUE_W-1:0] value,
                                                 logic signed [spq_pkg::PRIO_W-1:0] prio);
    spq_result_t r;
    int          pos;
    r.value  = '0;
    r.status = spq_pkg::ST_DONE;
    if (cmd == spq_pkg::CMD_REMOVE) begin
      if (queue_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.value = queue_value[0];
        for (int i = 1; i < queue_count; i++) begin
          queue_value[i-1] = queue_value[i];
          queue_prio[i-1]  = queue_prio[i];
        end
        queue_count--;
      end
    end else if (queue_count >= spq_pkg::CAPACITY) begin
      r.status = spq_pkg::ST_FULL;
    end else begin
      pos = 0;
      while (pos < queue_count && queue_prio[pos] <= prio) pos++;
      for (int i = queue_count; i > pos; i--) begin
        queue_value[i] = queue_value[i-1];
        queue_prio[i]  = queue_prio[i-1];
      end
      queue_value[pos] = value;
      queue_prio[pos]  = prio;
      queue_count++;
    end
    r.occ = spq_pkg::OCC_W'(queue_count);
    return r;
  endfunction

  function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority(bit narrow);
    if (narrow) begin
      return spq_pkg::PRIO_W'($urandom_range(0, 4)) - spq_pkg::PRIO_W'(2);
    end
    return spq_pkg::PRIO_W'($urandom);
  endfunction

  function automatic logic [spq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      default: return spq_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  // Called at a rising edge; returns at a rising edge once the request has been taken.
  task automatic send_request(spq_pkg::command_e cmd, logic [spq_pkg::VALUE_W-1:0] value,
                              logic [spq_pkg::PRIO_W-1:0] prio);
    spq_result_t r;
    int          gap;
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    entry_value_i    <= value;
    entry_priority_i <= prio;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_result(cmd, value, prio);
    pending_results.push_back(r);
    if (cmd == spq_pkg::CMD_REMOVE) remove_count++;
    else insert_count++;
    if (r.status == spq_pkg::ST_FULL) full_count++;
    if (r.status == spq_pkg::ST_EMPTY) empty_count++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic report_mismatch(spq_result_t want, bit have_want);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      if (have_want) begin
        $display("ERROR: result %0d expected value %0d status %0d occupancy %0d",
                 checked_count, want.value, want.status, want.occ);
        $display("       got value %0d status %0d occupancy %0d",
                 removed_value_o, status_o, occupancy_o);
      end else begin
        $display("ERROR: unexpected result value %0d status %0d occupancy %0d",
                 removed_value_o, status_o, occupancy_o);
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    spq_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        want = '0;
        report_mismatch(want, 1'b0);
      end else begin
        want = pending_results.pop_front();
        if (removed_value_o !== want.value || status_o !== want.status ||
            occupancy_o !== want.occ) begin
          report_mismatch(want, 1'b1);
        end
        checked_count++;
      end
    end
  end

  initial begin : result_receiver
    int mode;
    int mode_left;
    int period;
    int phase;
    mode      = RX_FREE;
    mode_left = 0;
    period    = 3;
    phase     = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(RX_FREE, RX_PERIODIC);
          mode_left = $urandom_range(20, 150);
          period    = $urandom_range(2, 7);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_FREE:     out_ready_i <= 1'b1;
          RX_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
          RX_SLOW:     out_ready_i <= ($urandom_range(0, 3) == 0);
          default:     out_ready_i <= ((phase % period) != 0);
        endcase
      end
    end
  end

  task automatic test_directed();
    send_request(spq_pkg::CMD_REMOVE, 32'h1234_5678, 16'h0);
    send_request(spq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
    send_request(spq_pkg::CMD_INSERT, 32'h8000_0000, 16'h8000);
    send_request(spq_pkg::CMD_INSERT, 32'h0000_0000, 16'h0000);
    send_request(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(spq_pkg::CMD_INSERT, 32'h0000_0001, 16'h0000);
    send_request(spq_pkg::CMD_INSERT, 32'h0000_0002, 16'h0000);
    send_request(spq_pkg::CMD_INSERT, 32'h5555_5555, 16'h7FFF);
    send_request(spq_pkg::CMD_INSERT, 32'hAAAA_AAAA, 16'h8000);
    repeat (8) send_request(spq_pkg::CMD_REMOVE, spq_pkg::VALUE_W'($urandom),
                            spq_pkg::PRIO_W'($urandom));
    send_request(spq_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_capacity();
    repeat (spq_pkg::CAPACITY) send_request(spq_pkg::CMD_INSERT, pick_value(),
                                            pick_priority(1'b1));
    repeat (2) send_request(spq_pkg::CMD_INSERT, pick_value(), pick_priority(1'b0));
    send_request(spq_pkg::CMD_REMOVE, pick_value(), pick_priority(1'b0));
    send_request(spq_pkg::CMD_INSERT, pick_value(), pick_priority(1'b1));
    repeat (spq_pkg::CAPACITY + 1) send_request(spq_pkg::CMD_REMOVE, pick_value(),
                                                pick_priority(1'b0));
  endtask

  task automatic test_fill_drain(int num_items);
    int  sent;
    int  target;
    int  drain;
    bit  narrow;
    sent = 0;
    while (sent < num_items) begin
      target  = $urandom_range(1, spq_pkg::CAPACITY + 2);
      narrow  = 1'($urandom_range(0, 1));
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (target) send_request(spq_pkg::CMD_INSERT, pick_value(), pick_priority(narrow));
      drain = queue_count + $urandom_range(0, 1);
      repeat (drain) send_request(spq_pkg::CMD_REMOVE, pick_value(), pick_priority(1'b0));
      sent += target + drain;
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_mix(int num_items);
    int  insert_pct;
    bit  narrow;
    for (int n = 0; n < num_items; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          2:       insert_pct = 75;
          default: insert_pct = 90;
        endcase
        narrow  = 1'($urandom_range(0, 1));
        gaps_on = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 99) < insert_pct) begin
        send_request(spq_pkg::CMD_INSERT, pick_value(), pick_priority(narrow));
      end else begin
        send_request(spq_pkg::CMD_REMOVE, pick_value(), pick_priority(1'b0));
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 3) != 0) begin
        send_request(spq_pkg::CMD_INSERT, pick_value(), pick_priority(1'b1));
      end else begin
        send_request(spq_pkg::CMD_REMOVE, pick_value(), pick_priority(1'b0));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_capacity();
    test_fill_drain(500);
    test_backpressure();
    test_random_mix(750);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) error_count++;

    $display("Sent %0d inserts and %0d removes, with %0d full rejects and %0d empty removes.",
             insert_count, remove_count, full_count, empty_count);
    $display("Checked %0d results under random gaps, stalls and a long output hold-off.",
             checked_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches in total.", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue.sv
dv/stable_priority_queue_tb.sv
